/* rtl/core/gain_stage_level_meter_macros.svh */
// Assertion macros shared by the gain stage and level meter RTL.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef GAIN_STAGE_LEVEL_METER_MACROS_SVH
`define GAIN_STAGE_LEVEL_METER_MACROS_SVH

// Condition that must hold at every clock edge.
`define GSLM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold in the same cycle as its trigger.
`define GSLM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define GSLM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/gslm_pkg.sv */
// Shared constants and types for the gain stage and level meter.
// No dependencies; the multiplier, window, level unit and top level import this package.
`timescale 1ns / 1ps

package gslm_pkg;

   // moving window; the depth is a power of two
   localparam int WINDOW_DEPTH = 256;
   localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int MAG_W        = 17;
   localparam int SUM_W        = MAG_W + POS_W;

   // level computation
   localparam int AVG_SHIFT  = 25;
   // sum * 2^AVG_SHIFT / WINDOW_DEPTH is a plain left shift
   localparam int AVG_SHL    = AVG_SHIFT - POS_W;
   localparam int V_W        = 42;
   localparam int NORM_W     = $clog2(V_W);
   localparam int MANT_W     = 31;
   localparam int MANT_FB    = 30;
   localparam int FRAC_W     = 16;
   localparam int ITER_W     = $clog2(FRAC_W);
   localparam int LOG_Q      = 40;
   localparam int EXP_W      = 8;
   localparam int DB_SHIFT   = 24;
   localparam logic [V_W-1:0] EPS_Q40 = 42'd1099512;

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam logic signed [MUL_W-1:0]  DB_PER_OCTAVE = 32'sd394566;
   localparam logic signed [PROD_W-1:0] DB_ROUND      = 64'sd8388608;

   // level limits, 1/256 dB
   localparam int DB_W = 16;
   typedef logic signed [DB_W-1:0] level_type;
   localparam level_type LEVEL_MIN   = -16'sd15360;
   localparam level_type LEVEL_MAX   = 16'sd1536;
   localparam level_type LEVEL_FLOOR = -16'sd20480;

   // action codes
   localparam logic [1:0] ACT_SAMPLE    = 2'd0;
   localparam logic [1:0] ACT_BLOCK_END = 2'd1;
   localparam logic [1:0] ACT_CLEAR     = 2'd2;

   // register file
   localparam int ADDR_W = 3;
   localparam logic [ADDR_W-3:0] CSR_GAIN_IDX = 1'b0;
   localparam logic [15:0] GAIN_RESET = 16'd16384;

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             rd;
      logic             push;
      logic             clear;
      logic [MAG_W-1:0] mag;
   } win_cmd_type;

endpackage

/* rtl/core/gslm_if.sv */
// Valid/ready channel interfaces for sample words in and result words out.
// Stand-alone; used by the gain stage and level meter top level.
`timescale 1ns / 1ps

interface gslm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] raw_sample;
   logic [2:0]         channel;

   modport source (output valid, action, raw_sample, channel, input ready);
   modport sink   (input valid, action, raw_sample, channel, output ready);
endinterface

interface gslm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] scaled_sample;
   logic signed [14:0] level_db;
   logic               is_level;

   modport source (output valid, scaled_sample, level_db, is_level, input ready);
   modport sink   (input valid, scaled_sample, level_db, is_level, output ready);
endinterface

/* rtl/core/gslm_mul.sv */
// Shared signed 32x32 multiplier with a registered product.
// Depends on gslm_pkg.
`timescale 1ns / 1ps

module gslm_mul (
   input  logic                                clock,
   input  gslm_pkg::mul_req_type               req,
   output logic signed [gslm_pkg::PROD_W-1:0]  prod
);
   import gslm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = req.a * req.b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* rtl/core/gslm_window.sv */
// Moving window store of sample magnitudes with running sum and clearing pass.
// Depends on gslm_pkg.
`timescale 1ns / 1ps

module gslm_window (
   input  logic                          clock,
   input  logic                          reset,
   input  gslm_pkg::win_cmd_type         cmd,
   output logic [gslm_pkg::SUM_W-1:0]    sum,
   output logic                          busy
);
   import gslm_pkg::*;

   logic [MAG_W-1:0] mem [WINDOW_DEPTH];
   logic [MAG_W-1:0] rd_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             sweep_ff, sweep_in;
   logic [POS_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic             wr_en;
   logic [POS_W-1:0] wr_addr;
   logic [MAG_W-1:0] wr_data;

   always_comb begin
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = cmd.mag;
      if (sweep_ff) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = '0;
         if (sweep_addr_ff == POS_W'(WINDOW_DEPTH - 1)) begin
            sweep_in = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
         end
      end else if (cmd.clear) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
         pos_in        = '0;
         sum_in        = '0;
      end else if (cmd.push) begin
         wr_en  = 1'b1;
         // drop the oldest magnitude, add the new one
         sum_in = sum_ff - SUM_W'(rd_ff) + SUM_W'(cmd.mag);
         pos_in = (pos_ff == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         sum_ff        <= '0;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_ff <= mem[pos_ff];
      end
   end

   assign sum  = sum_ff;
   assign busy = sweep_ff;

endmodule

/* rtl/core/gslm_log.sv */
// Level unit: window average by shift, log2 by repeated squaring, dB scaling.
// Depends on gslm_pkg and drives the shared multiplier through a request struct.
`timescale 1ns / 1ps
`include "gain_stage_level_meter_macros.svh"

module gslm_log (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [gslm_pkg::SUM_W-1:0]          sum,
   input  logic signed [gslm_pkg::PROD_W-1:0]  prod,
   output gslm_pkg::mul_req_type               mul_req,
   output logic                                busy,
   output logic                                done,
   output gslm_pkg::level_type                 db
);
   import gslm_pkg::*;

   typedef enum logic [2:0] {
      L_IDLE, L_ADD, L_NORM, L_SQR_MUL, L_SQR_UPD, L_DB_MUL, L_DB_FIN
   } log_state_type;

   log_state_type           state_ff, state_in;
   logic [V_W-1:0]          q_ff, q_in;
   logic [V_W-1:0]          v_ff, v_in;
   logic [NORM_W-1:0]       n_ff, n_in;
   logic [MANT_W-1:0]       m_ff, m_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   level_type               db_ff, db_in;
   logic                    done_ff, done_in;

   logic [MANT_W:0]                sq;
   logic signed [EXP_W-1:0]        exp_v;
   logic signed [EXP_W+FRAC_W-1:0] l_v;
   logic signed [PROD_W-1:0]       rnd;
   logic signed [PROD_W-DB_SHIFT-1:0] dbw;

   always_comb begin
      sq    = prod[2*MANT_FB+1:MANT_FB];
      exp_v = EXP_W'(V_W - 1 - LOG_Q) - EXP_W'(n_ff);
      l_v   = {exp_v, frac_ff};
      rnd   = prod + DB_ROUND;
      dbw   = $signed(rnd[PROD_W-1:DB_SHIFT]);
   end

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      v_in     = v_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      iter_in  = iter_ff;
      db_in    = db_ff;
      done_in  = 1'b0;
      mul_req  = '0;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               // average in Q.40: scale the sum up and divide by the depth in one shift
               q_in     = V_W'({sum, {AVG_SHL{1'b0}}});
               state_in = L_ADD;
            end
         end
         L_ADD: begin
            v_in     = q_ff + EPS_Q40;
            n_in     = '0;
            state_in = L_NORM;
         end
         L_NORM: begin
            if (v_ff[V_W-1]) begin
               m_in     = v_ff[V_W-1 -: MANT_W];
               frac_in  = '0;
               iter_in  = '0;
               state_in = L_SQR_MUL;
            end else begin
               v_in = v_ff << 1;
               n_in = n_ff + 1'b1;
            end
         end
         L_SQR_MUL: begin
            mul_req.a = MUL_W'(m_ff);
            mul_req.b = MUL_W'(m_ff);
            state_in  = L_SQR_UPD;
         end
         L_SQR_UPD: begin
            // square at or above 2.0 yields a one bit and a halved mantissa
            if (sq[MANT_W]) begin
               m_in    = sq[MANT_W:1];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               m_in    = sq[MANT_W-1:0];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            end
            if (iter_ff == ITER_W'(FRAC_W - 1)) begin
               state_in = L_DB_MUL;
            end else begin
               iter_in  = iter_ff + 1'b1;
               state_in = L_SQR_MUL;
            end
         end
         L_DB_MUL: begin
            mul_req.a = MUL_W'(l_v);
            mul_req.b = DB_PER_OCTAVE;
            state_in  = L_DB_FIN;
         end
         L_DB_FIN: begin
            if (dbw < (PROD_W - DB_SHIFT)'(LEVEL_FLOOR)) begin
               db_in = LEVEL_FLOOR;
            end else begin
               db_in = dbw[DB_W-1:0];
            end
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      q_ff    <= q_in;
      v_ff    <= v_in;
      n_ff    <= n_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      iter_ff <= iter_in;
      db_ff   <= db_in;
   end

   assign busy = (state_ff != L_IDLE);
   assign done = done_ff;
   assign db   = db_ff;

   `GSLM_ASSERT_IMPLY(a_start_when_idle, start, state_ff == L_IDLE, "level start while busy")
   `GSLM_ASSERT_IMPLY(a_norm_nonzero, state_ff == L_NORM, v_ff != '0, "normalising a zero value")
   `GSLM_ASSERT_IMPLY(a_square_range, state_ff == L_SQR_UPD,
      prod[PROD_W-1:2*MANT_FB+2] == '0, "square out of range")
   `GSLM_ASSERT_IMPLY(a_db_floor, done_ff, db_ff >= LEVEL_FLOOR, "level below floor")

endmodule

/* rtl/core/gain_stage_level_meter.sv */
// Gain stage and moving-average level meter: one input word in, one result word out.
// A sample word makes one pass through the shared 32x32 multiplier while the window
// store is read, then rounding and saturation; on channel 0 it is then written into
// the window store. An end-of-block word runs the level unit: the window average is a
// single shift as the depth is a power of two, then 1 to 22 normalising steps, 16
// squaring steps on the shared multiplier, then dB scaling, peak hold and clamp. An
// unused action goes straight to the output register.
// After reset and after a clear word the window store is zeroed by a clearing pass
// over all WINDOW_DEPTH (256) entries during which no word is accepted; register
// writes are taken at any time. A finished result waits in the output register while
// the next word is accepted.
`timescale 1ns / 1ps
`include "gain_stage_level_meter_macros.svh"

module gain_stage_level_meter (
   input  logic                          clock,
   input  logic                          reset,
   gslm_req_if.sink                      req,
   gslm_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gslm_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import gslm_pkg::*;

   typedef enum logic [3:0] {
      S_WIPE, S_IDLE, S_MUL, S_SCALE, S_PUSH, S_LOG, S_LOGW, S_HOLD, S_CLR, S_CLRW, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [15:0]        gain_ff, gain_in;
   logic signed [15:0] raw_ff, raw_in;
   logic [2:0]         chan_ff, chan_in;
   logic signed [16:0] scaled_ff, scaled_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               is_level_ff, is_level_in;
   level_type          db_ff, db_in;
   level_type          last_level_ff, last_level_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [16:0] rsp_scaled_ff, rsp_scaled_in;
   logic signed [14:0] rsp_level_ff, rsp_level_in;
   logic               rsp_is_level_ff, rsp_is_level_in;

   mul_req_type              gain_req, log_req, mul_req;
   logic signed [PROD_W-1:0] mul_prod;
   win_cmd_type              win_cmd;
   logic [SUM_W-1:0]         win_sum;
   logic                     win_busy;
   logic                     log_start, log_busy, log_done;
   level_type                log_db;

   logic signed [33:0]  gprod, grnd;
   logic signed [19:0]  gshift;
   logic signed [16:0]  scaled_sat;
   logic signed [16:0]  hsum;
   level_type           held, clamped;
   logic                csr_wr;

   gslm_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (mul_prod)
   );

   gslm_window u_window (
      .clock (clock),
      .reset (reset),
      .cmd   (win_cmd),
      .sum   (win_sum),
      .busy  (win_busy)
   );

   gslm_log u_log (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .sum     (win_sum),
      .prod    (mul_prod),
      .mul_req (log_req),
      .busy    (log_busy),
      .done    (log_done),
      .db      (log_db)
   );

   assign mul_req = log_busy ? log_req : gain_req;

   // register port
   assign csr_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == CSR_GAIN_IDX);
   assign gain_in = csr_wr ? pwdata[15:0] : gain_ff;
   assign prdata  = (paddr[ADDR_W-1:2] == CSR_GAIN_IDX) ? 32'(gain_ff) : '0;
   assign pready  = 1'b1;

   // round Q2.29 product to Q2.15, halves upward, then saturate
   always_comb begin
      gprod  = $signed(mul_prod[33:0]);
      grnd   = gprod + 34'sd8192;
      gshift = $signed(grnd[33:14]);
      if (gshift > 20'sd65535) begin
         scaled_sat = 17'sd65535;
      end else if (gshift < -20'sd65536) begin
         scaled_sat = -17'sd65536;
      end else begin
         scaled_sat = gshift[16:0];
      end
   end

   // peak hold: average toward a falling level, then clamp
   always_comb begin
      hsum = 17'(last_level_ff) + 17'(db_ff);
      held = (db_ff < last_level_ff) ? $signed(hsum[16:1]) : db_ff;
      if (held < LEVEL_MIN) begin
         clamped = LEVEL_MIN;
      end else if (held > LEVEL_MAX) begin
         clamped = LEVEL_MAX;
      end else begin
         clamped = held;
      end
   end

   always_comb begin
      state_in        = state_ff;
      raw_in          = raw_ff;
      chan_in         = chan_ff;
      scaled_in       = scaled_ff;
      mag_in          = mag_ff;
      is_level_in     = is_level_ff;
      db_in           = db_ff;
      last_level_in   = last_level_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_scaled_in   = rsp_scaled_ff;
      rsp_level_in    = rsp_level_ff;
      rsp_is_level_in = rsp_is_level_ff;
      win_cmd         = '0;
      gain_req        = '0;
      log_start       = 1'b0;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_WIPE: begin
            if (!win_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               raw_in      = req.raw_sample;
               chan_in     = req.channel;
               scaled_in   = '0;
               is_level_in = 1'b0;
               case (req.action)
                  ACT_SAMPLE:    state_in = S_MUL;
                  ACT_BLOCK_END: state_in = S_LOG;
                  ACT_CLEAR:     state_in = S_CLR;
                  default:       state_in = S_OUT;
               endcase
            end
         end
         S_MUL: begin
            gain_req.a = MUL_W'(raw_ff);
            gain_req.b = MUL_W'(gain_ff);
            win_cmd.rd = 1'b1;
            state_in   = S_SCALE;
         end
         S_SCALE: begin
            scaled_in = scaled_sat;
            mag_in    = scaled_sat[16] ? MAG_W'(~scaled_sat + 17'sd1) : MAG_W'(scaled_sat);
            state_in  = (chan_ff == '0) ? S_PUSH : S_OUT;
         end
         S_PUSH: begin
            win_cmd.push = 1'b1;
            win_cmd.mag  = mag_ff;
            state_in     = S_OUT;
         end
         S_LOG: begin
            log_start = 1'b1;
            state_in  = S_LOGW;
         end
         S_LOGW: begin
            if (log_done) begin
               db_in    = log_db;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            last_level_in = clamped;
            is_level_in   = 1'b1;
            state_in      = S_OUT;
         end
         S_CLR: begin
            win_cmd.clear = 1'b1;
            last_level_in = LEVEL_MIN;
            state_in      = S_CLRW;
         end
         S_CLRW: begin
            if (!win_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_scaled_in   = scaled_ff;
               rsp_level_in    = last_level_ff[14:0];
               rsp_is_level_in = is_level_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_WIPE;
         gain_ff       <= GAIN_RESET;
         last_level_ff <= LEVEL_MIN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_ff       <= gain_in;
         last_level_ff <= last_level_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      raw_ff          <= raw_in;
      chan_ff         <= chan_in;
      scaled_ff       <= scaled_in;
      mag_ff          <= mag_in;
      is_level_ff     <= is_level_in;
      db_ff           <= db_in;
      rsp_scaled_ff   <= rsp_scaled_in;
      rsp_level_ff    <= rsp_level_in;
      rsp_is_level_ff <= rsp_is_level_in;
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.scaled_sample = rsp_scaled_ff;
   assign rsp.level_db      = rsp_level_ff;
   assign rsp.is_level      = rsp_is_level_ff;

   `GSLM_ASSERT_IMPLY(a_level_range, rsp_valid_ff,
      (rsp_level_ff >= 15'(LEVEL_MIN)) && (rsp_level_ff <= 15'(LEVEL_MAX)), "level out of range")
   `GSLM_ASSERT_IMPLY(a_level_no_sample, rsp_valid_ff && rsp_is_level_ff,
      rsp_scaled_ff == '0, "level word carries a sample")
   `GSLM_ASSERT_IMPLY(a_accept_units_idle, req.valid && req.ready,
      !log_busy && !win_busy, "word taken while a unit is busy")
   `GSLM_ASSERT_NEXT(a_out_load, (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready),
      rsp_valid_ff && (state_ff == S_IDLE), "result not loaded")

endmodule
